// File: rtl/voxel_face_cull_mesher_unit_defines.svh
// Assertion macros shared by the mesher RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH
`define VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define VFCM_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VFCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/vfcm_pkg.sv
// Shared types and codes for the voxel face-culling mesher.
// No dependencies.
package vfcm_pkg;

	localparam int CHUNK_X_DEF = 16;
	localparam int CHUNK_Y_DEF = 32;
	localparam int CHUNK_Z_DEF = 16;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_RESTART = 2'd1;
	localparam logic [1:0] MODE_MESH    = 2'd2;

	localparam logic [2:0] KIND_AIR     = 3'd0;
	localparam logic [2:0] KIND_DIRT    = 3'd1;
	localparam logic [2:0] KIND_GRASS   = 3'd2;
	localparam logic [2:0] KIND_BEDROCK = 3'd3;
	localparam logic [2:0] KIND_LOG     = 3'd4;
	localparam logic [2:0] KIND_LEAVES  = 3'd5;

	localparam logic [2:0] FACE_PZ = 3'd0;
	localparam logic [2:0] FACE_NZ = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PX = 3'd4;
	localparam logic [2:0] FACE_NX = 3'd5;

	// read selects: center cell, then the six neighbours in face order
	localparam logic [2:0] SEL_CENTER = 3'd0;
	localparam logic [2:0] SEL_PZ     = 3'd1;
	localparam logic [2:0] SEL_NZ     = 3'd2;
	localparam logic [2:0] SEL_PY     = 3'd3;
	localparam logic [2:0] SEL_NY     = 3'd4;
	localparam logic [2:0] SEL_PX     = 3'd5;
	localparam logic [2:0] SEL_NX     = 3'd6;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] pos_x_in;
		logic [4:0] pos_y_in;
		logic [3:0] pos_z_in;
		logic [2:0] block_kind;
	} vfcm_req_t;

	typedef struct packed {
		logic        face_valid;
		logic [3:0]  cell_x;
		logic [4:0]  cell_y;
		logic [3:0]  cell_z;
		logic [2:0]  face_dir;
		logic [3:0]  atlas_col;
		logic [3:0]  atlas_row;
		logic [15:0] base_vertex;
		logic        last_of_cell;
		logic        mesh_done;
	} vfcm_rec_t;

	typedef struct packed {
		logic       clear_wr;
		logic       write_blk;
		logic       restart;
		logic       rd_issue;
		logic [2:0] rd_sel;
		logic       emit;
	} vfcm_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
		logic emit_last;
	} vfcm_sts_t;

endpackage

// File: rtl/vfcm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module vfcm_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8192
) (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/vfcm_ctrl.sv
// Controller state machine of the mesher: clearing pass, request decode,
// neighbour read sequence and record emission. Depends on vfcm_pkg.
module vfcm_ctrl
	import vfcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] mode,
	output logic       in_ready,
	output vfcm_cmd_t  cmd,
	input  vfcm_sts_t  sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GATHER,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				cmd.write_blk = accept && (mode == MODE_WRITE);
				cmd.restart   = accept && (mode == MODE_RESTART);
				cmd.rd_issue  = accept && (mode == MODE_MESH);
				cmd.rd_sel    = SEL_CENTER;
			end
			ST_GATHER: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_sel   = step_q;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= SEL_CENTER;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (mode == MODE_MESH)) begin
						state_q <= ST_GATHER;
						step_q  <= SEL_PZ;
					end
				end
				ST_GATHER: begin
					if (step_q == SEL_NX) begin
						state_q <= ST_WAIT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free && sts.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/vfcm_dp.sv
// Datapath of the mesher: block store, scan cursor, vertex counter,
// face mask capture and output record register. Depends on vfcm_pkg, vfcm_ram.
`include "voxel_face_cull_mesher_unit_defines.svh"
module vfcm_dp
	import vfcm_pkg::*;
#(
	parameter int CHUNK_X = CHUNK_X_DEF,
	parameter int CHUNK_Y = CHUNK_Y_DEF,
	parameter int CHUNK_Z = CHUNK_Z_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  vfcm_req_t in_req,
	input  vfcm_cmd_t cmd,
	output vfcm_sts_t sts,
	output logic      out_valid,
	input  logic      out_ready,
	output vfcm_rec_t out_rec
);

	localparam int CELLS    = CHUNK_X * CHUNK_Y * CHUNK_Z;
	localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int XW       = (CHUNK_X > 1) ? $clog2(CHUNK_X) : 1;
	localparam int YW       = (CHUNK_Y > 1) ? $clog2(CHUNK_Y) : 1;
	localparam int ZW       = (CHUNK_Z > 1) ? $clog2(CHUNK_Z) : 1;
	localparam int STRIDE_Y = CHUNK_Z;
	localparam int STRIDE_X = CHUNK_Y * CHUNK_Z;

	localparam logic [XW-1:0] X_MAX    = XW'(CHUNK_X - 1);
	localparam logic [YW-1:0] Y_MAX    = YW'(CHUNK_Y - 1);
	localparam logic [ZW-1:0] Z_MAX    = ZW'(CHUNK_Z - 1);
	localparam logic [AW-1:0] CELL_MAX = AW'(CELLS - 1);

	function automatic logic [2:0] lowest_face(input logic [5:0] m);
		logic [2:0] f;
		f = FACE_PZ;
		for (int i = 5; i >= 0; i--) begin
			if (m[i]) begin
				f = 3'(i);
			end
		end
		return f;
	endfunction

	// {column, row}
	function automatic logic [7:0] atlas_of(input logic [2:0] kind, input logic [2:0] face);
		logic [7:0] r;
		case (kind)
			KIND_DIRT:    r = {4'd2, 4'd0};
			KIND_GRASS:   r = (face == FACE_PY) ? {4'd0, 4'd0} :
				(face == FACE_NY) ? {4'd2, 4'd0} : {4'd1, 4'd0};
			KIND_BEDROCK: r = {4'd3, 4'd0};
			KIND_LOG:     r = ((face == FACE_PY) || (face == FACE_NY)) ?
				{4'd5, 4'd0} : {4'd4, 4'd0};
			KIND_LEAVES:  r = {4'd6, 4'd0};
			default:      r = {4'd15, 4'd15};
		endcase
		return r;
	endfunction

	logic [AW-1:0] clr_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [ZW-1:0] z_q;
	logic [AW-1:0] cur_q;
	logic [15:0]   vc_q;
	logic [2:0]    kind_q;
	logic [5:0]    vis_q;
	logic          pend_s1;
	logic [2:0]    sel_s1;
	logic          inb_s1;
	logic          out_valid_q;
	vfcm_rec_t     out_q;

	logic [AW-1:0] rd_addr;
	logic          rd_inb;
	logic          wr_in_range;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] cur_chk;
	logic          ram_en;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [2:0]    ram_wdata;
	logic [2:0]    ram_rdata;
	logic          rd_solid;
	logic [5:0]    eff_mask;
	logic [2:0]    face;
	logic [5:0]    face_bit;
	logic          emit_last;
	logic          cell_done;
	logic [7:0]    atlas;
	vfcm_rec_t     rec;

	always_comb begin
		case (cmd.rd_sel)
			SEL_CENTER: begin
				rd_addr = cur_q;
				rd_inb  = 1'b1;
			end
			SEL_PZ: begin
				rd_addr = cur_q + AW'(1);
				rd_inb  = (z_q != Z_MAX);
			end
			SEL_NZ: begin
				rd_addr = cur_q - AW'(1);
				rd_inb  = (z_q != '0);
			end
			SEL_PY: begin
				rd_addr = cur_q + AW'(STRIDE_Y);
				rd_inb  = (y_q != Y_MAX);
			end
			SEL_NY: begin
				rd_addr = cur_q - AW'(STRIDE_Y);
				rd_inb  = (y_q != '0);
			end
			SEL_PX: begin
				rd_addr = cur_q + AW'(STRIDE_X);
				rd_inb  = (x_q != X_MAX);
			end
			SEL_NX: begin
				rd_addr = cur_q - AW'(STRIDE_X);
				rd_inb  = (x_q != '0);
			end
			default: begin
				rd_addr = cur_q;
				rd_inb  = 1'b0;
			end
		endcase
	end

	assign wr_in_range = (int'(in_req.pos_x_in) < CHUNK_X) &&
		(int'(in_req.pos_y_in) < CHUNK_Y) && (int'(in_req.pos_z_in) < CHUNK_Z);
	assign wr_addr = AW'((int'(in_req.pos_x_in) * CHUNK_Y + int'(in_req.pos_y_in)) * CHUNK_Z
		+ int'(in_req.pos_z_in));
	assign cur_chk = AW'((int'(x_q) * CHUNK_Y + int'(y_q)) * CHUNK_Z + int'(z_q));

	assign ram_en    = cmd.clear_wr || (cmd.write_blk && wr_in_range) || (cmd.rd_issue && rd_inb);
	assign ram_we    = cmd.clear_wr || cmd.write_blk;
	assign ram_addr  = cmd.clear_wr ? clr_q : (cmd.write_blk ? wr_addr : rd_addr);
	assign ram_wdata = cmd.clear_wr ? KIND_AIR : in_req.block_kind;

	vfcm_ram #(
		.WIDTH(3),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd_solid  = (ram_rdata != KIND_AIR) && (ram_rdata != KIND_LEAVES);
	assign eff_mask  = (kind_q != KIND_AIR) ? vis_q : 6'd0;
	assign face      = lowest_face(eff_mask);
	assign face_bit  = 6'd1 << face;
	assign emit_last = ((eff_mask & ~face_bit) == 6'd0);
	assign cell_done = (cur_q == CELL_MAX);
	assign atlas     = atlas_of(kind_q, face);

	always_comb begin
		rec              = '0;
		rec.face_valid   = (eff_mask != 6'd0);
		rec.cell_x       = 4'(x_q);
		rec.cell_y       = 5'(y_q);
		rec.cell_z       = 4'(z_q);
		rec.face_dir     = rec.face_valid ? face : FACE_PZ;
		rec.atlas_col    = rec.face_valid ? atlas[7:4] : 4'd0;
		rec.atlas_row    = rec.face_valid ? atlas[3:0] : 4'd0;
		rec.base_vertex  = vc_q;
		rec.last_of_cell = emit_last;
		rec.mesh_done    = cell_done;
	end

	assign sts.clear_last = (clr_q == CELL_MAX);
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.emit_last  = emit_last;

	assign out_valid = out_valid_q;
	assign out_rec   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			cur_q       <= '0;
			vc_q        <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			pend_s1 <= cmd.rd_issue;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.restart) begin
				x_q   <= '0;
				y_q   <= '0;
				z_q   <= '0;
				cur_q <= '0;
				vc_q  <= '0;
			end else if (cmd.emit) begin
				if (emit_last && cell_done) begin
					vc_q <= '0;
				end else if (rec.face_valid) begin
					vc_q <= vc_q + 16'd4;
				end
				if (emit_last) begin
					if (cell_done) begin
						x_q   <= '0;
						y_q   <= '0;
						z_q   <= '0;
						cur_q <= '0;
					end else begin
						cur_q <= cur_q + AW'(1);
						if (z_q == Z_MAX) begin
							z_q <= '0;
							if (y_q == Y_MAX) begin
								y_q <= '0;
								x_q <= x_q + XW'(1);
							end else begin
								y_q <= y_q + YW'(1);
							end
						end else begin
							z_q <= z_q + ZW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= cmd.rd_sel;
		inb_s1 <= rd_inb;
		if (pend_s1) begin
			if (sel_s1 == SEL_CENTER) begin
				kind_q <= ram_rdata;
			end else begin
				vis_q[3'(sel_s1 - SEL_PZ)] <= !(inb_s1 && rd_solid);
			end
		end
		if (cmd.emit) begin
			out_q <= rec;
			vis_q <= vis_q & ~face_bit;
		end
	end

	`VFCM_ASSERT(a_vc_aligned, 1'b1, vc_q[1:0] == 2'd0, "vertex counter not a multiple of four")
	`VFCM_ASSERT(a_cursor_coords, 1'b1, cur_q == cur_chk, "scan cursor out of step with coordinates")
	`VFCM_ASSERT_NEXT(a_empty_record, cmd.emit && (eff_mask == 6'd0), !out_q.face_valid && out_q.last_of_cell, "empty cell record malformed")
	`VFCM_ASSERT(a_capture_after_read, pend_s1, $past(cmd.rd_issue), "store capture without a read")

endmodule

// File: rtl/voxel_face_cull_mesher_unit.sv
// Mesh request: after accept the controller reads the cell and its neighbours, then
// loads one record a cycle while the output is free; the next request is taken the
// cycle after the last record is loaded. Each cell takes 7 read steps on the single block-store port.
// Write and restart requests keep the unit idle. After reset a clearing pass writes
// air to all CHUNK_X*CHUNK_Y*CHUNK_Z cells, no request taken.
// Top level of the voxel face-culling mesher. Depends on vfcm_pkg, vfcm_ctrl, vfcm_dp.
module voxel_face_cull_mesher_unit
	import vfcm_pkg::*;
#(
	parameter int CHUNK_X = CHUNK_X_DEF,
	parameter int CHUNK_Y = CHUNK_Y_DEF,
	parameter int CHUNK_Z = CHUNK_Z_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  vfcm_req_t in_req,
	output logic      out_valid,
	input  logic      out_ready,
	output vfcm_rec_t out_rec
);

	vfcm_cmd_t cmd;
	vfcm_sts_t sts;

	vfcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.mode    (in_req.mode),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	vfcm_dp #(
		.CHUNK_X(CHUNK_X),
		.CHUNK_Y(CHUNK_Y),
		.CHUNK_Z(CHUNK_Z)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_req   (in_req),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rec  (out_rec)
	);

endmodule

// File: tb/tb.sv
// Self-checking testbench for voxel_face_cull_mesher_unit: requests are driven with
// bursts and gaps while an in-bench face-culling predictor checks every emitted record.
// Depends on vfcm_pkg and the mesher RTL.
module tb;
	import vfcm_pkg::*;

	localparam int CX = CHUNK_X_DEF;
	localparam int CY = CHUNK_Y_DEF;
	localparam int CZ = CHUNK_Z_DEF;
	localparam int CELLS = CX * CY * CZ;
	localparam int RANDOM_ITEMS = 50;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1500000;

	localparam logic [1:0] MODE_IDLE = 2'd3;
	localparam logic [2:0] KIND_UNK_LO = 3'd6;
	localparam logic [2:0] KIND_UNK_HI = 3'd7;

	localparam logic [3:0] ATLAS_GRASS_TOP  = 4'd0;
	localparam logic [3:0] ATLAS_GRASS_SIDE = 4'd1;
	localparam logic [3:0] ATLAS_DIRT       = 4'd2;
	localparam logic [3:0] ATLAS_BEDROCK    = 4'd3;
	localparam logic [3:0] ATLAS_LOG_SIDE   = 4'd4;
	localparam logic [3:0] ATLAS_LOG_END    = 4'd5;
	localparam logic [3:0] ATLAS_LEAVES     = 4'd6;
	localparam logic [3:0] ATLAS_ERROR      = 4'd15;
	localparam logic [3:0] ATLAS_ROW_PLAIN  = 4'd0;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PERIODIC,
		SINK_HEAVY
	} sink_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	vfcm_req_t in_req;
	logic out_valid;
	logic out_ready;
	vfcm_rec_t out_rec;

	logic [2:0] voxel_kind [CELLS];
	int scan_pos;
	logic [15:0] vertex_base;
	vfcm_rec_t pending_faces [$];

	sink_mode_e sink_mode = SINK_OPEN;
	bit long_hold = 1'b0;
	bit steady_feed = 1'b0;
	bit failed = 1'b0;
	int burst_left = 0;
	int cycle_count = 0;

	voxel_face_cull_mesher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rec(out_rec)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int cell_index(int x, int y, int z);
		return (x * CY + y) * CZ + z;
	endfunction

	function automatic bit blocks_view(int x, int y, int z);
		logic [2:0] k;
		if (x < 0 || x >= CX || y < 0 || y >= CY || z < 0 || z >= CZ)
			return 1'b0;
		k = voxel_kind[cell_index(x, y, z)];
		return k != KIND_AIR && k != KIND_LEAVES;
	endfunction

	function automatic bit face_visible(int x, int y, int z, logic [2:0] face);
		case (face)
			FACE_PZ: return !blocks_view(x, y, z + 1);
			FACE_NZ: return !blocks_view(x, y, z - 1);
			FACE_PY: return !blocks_view(x, y + 1, z);
			FACE_NY: return !blocks_view(x, y - 1, z);
			FACE_PX: return !blocks_view(x + 1, y, z);
			default: return !blocks_view(x - 1, y, z);
		endcase
	endfunction

	// {row, col} of the atlas cell for a kind and face
	function automatic logic [7:0] atlas_cell(logic [2:0] kind, logic [2:0] face);
		case (kind)
			KIND_DIRT: return {ATLAS_ROW_PLAIN, ATLAS_DIRT};
			KIND_GRASS: begin
				if (face == FACE_PY)
					return {ATLAS_ROW_PLAIN, ATLAS_GRASS_TOP};
				if (face == FACE_NY)
					return {ATLAS_ROW_PLAIN, ATLAS_DIRT};
				return {ATLAS_ROW_PLAIN, ATLAS_GRASS_SIDE};
			end
			KIND_BEDROCK: return {ATLAS_ROW_PLAIN, ATLAS_BEDROCK};
			KIND_LOG: begin
				if (face == FACE_PY || face == FACE_NY)
					return {ATLAS_ROW_PLAIN, ATLAS_LOG_END};
				return {ATLAS_ROW_PLAIN, ATLAS_LOG_SIDE};
			end
			KIND_LEAVES: return {ATLAS_ROW_PLAIN, ATLAS_LEAVES};
			default: return {ATLAS_ERROR, ATLAS_ERROR};
		endcase
	endfunction

	task automatic predict_faces(input vfcm_req_t r);
		vfcm_rec_t recs [6];
		logic [2:0] kind;
		logic [2:0] face;
		logic [7:0] tex;
		logic done;
		int x, y, z, n, f, cur;
		case (r.mode)
			MODE_WRITE: begin
				if (r.pos_x_in < CX && r.pos_y_in < CY && r.pos_z_in < CZ)
					voxel_kind[cell_index(int'(r.pos_x_in), int'(r.pos_y_in),
						int'(r.pos_z_in))] = r.block_kind;
			end
			MODE_RESTART: begin
				scan_pos = 0;
				vertex_base = '0;
			end
			MODE_MESH: begin
				cur = (scan_pos >= CELLS) ? 0 : scan_pos;
				z = cur % CZ;
				y = (cur / CZ) % CY;
				x = cur / (CZ * CY);
				done = (cur == CELLS - 1);
				kind = voxel_kind[cur];
				n = 0;
				if (kind != KIND_AIR) begin
					for (f = 0; f < 6; f++) begin
						face = 3'(f);
						if (face_visible(x, y, z, face)) begin
							tex = atlas_cell(kind, face);
							recs[n] = '0;
							recs[n].face_valid = 1'b1;
							recs[n].cell_x = 4'(x);
							recs[n].cell_y = 5'(y);
							recs[n].cell_z = 4'(z);
							recs[n].face_dir = face;
							recs[n].atlas_col = tex[3:0];
							recs[n].atlas_row = tex[7:4];
							recs[n].base_vertex = vertex_base;
							recs[n].mesh_done = done;
							vertex_base = vertex_base + 16'd4;
							n++;
						end
					end
				end
				if (n == 0) begin
					recs[0] = '0;
					recs[0].cell_x = 4'(x);
					recs[0].cell_y = 5'(y);
					recs[0].cell_z = 4'(z);
					recs[0].base_vertex = vertex_base;
					recs[0].mesh_done = done;
					n = 1;
				end
				recs[n - 1].last_of_cell = 1'b1;
				for (f = 0; f < n; f++)
					pending_faces = {pending_faces, recs[f]};
				if (done) begin
					scan_pos = 0;
					vertex_base = '0;
				end else begin
					scan_pos = cur + 1;
				end
			end
			default: ;
		endcase
	endtask

	function automatic vfcm_req_t build_req(logic [1:0] mode, logic [3:0] x, logic [4:0] y,
			logic [3:0] z, logic [2:0] kind);
		vfcm_req_t r;
		r.mode = mode;
		r.pos_x_in = x;
		r.pos_y_in = y;
		r.pos_z_in = z;
		r.block_kind = kind;
		return r;
	endfunction

	function automatic vfcm_req_t random_req(logic [1:0] mode);
		return build_req(mode, 4'($urandom), 5'($urandom), 4'($urandom), 3'($urandom));
	endfunction

	function automatic logic [2:0] random_solid();
		logic [2:0] k;
		k = 3'($urandom_range(1, 6));
		return (k == KIND_LEAVES) ? KIND_UNK_HI : k;
	endfunction

	task automatic send_request(input vfcm_req_t r);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!steady_feed && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 10);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (!in_ready);
		predict_faces(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_faces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		vfcm_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_faces.size() == 0) begin
				$error("face record with none pending: %p", out_rec);
				failed = 1'b1;
			end else begin
				want = pending_faces.pop_front();
				check_field("face_valid", 16'(want.face_valid), 16'(out_rec.face_valid));
				check_field("cell_x", 16'(want.cell_x), 16'(out_rec.cell_x));
				check_field("cell_y", 16'(want.cell_y), 16'(out_rec.cell_y));
				check_field("cell_z", 16'(want.cell_z), 16'(out_rec.cell_z));
				check_field("face_dir", 16'(want.face_dir), 16'(out_rec.face_dir));
				check_field("atlas_col", 16'(want.atlas_col), 16'(out_rec.atlas_col));
				check_field("atlas_row", 16'(want.atlas_row), 16'(out_rec.atlas_row));
				check_field("base_vertex", want.base_vertex, out_rec.base_vertex);
				check_field("last_of_cell", 16'(want.last_of_cell),
					16'(out_rec.last_of_cell));
				check_field("mesh_done", 16'(want.mesh_done), 16'(out_rec.mesh_done));
			end
		end
	end

	initial begin : receiver
		int unsigned tick;
		tick = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else begin
				case (sink_mode)
					SINK_OPEN: out_ready <= 1'b1;
					SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
					SINK_PERIODIC: out_ready <= ((tick % 7) >= 3);
					default: out_ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	// one column of every kind, then meshing across it from a fresh scan
	task automatic test_kinds_and_faces();
		int z;
		sink_mode = SINK_RANDOM;
		send_request(build_req(MODE_MESH, '0, '0, '0, '0));
		send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'd1, KIND_UNK_HI));
		send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'd2, KIND_GRASS));
		send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'd3, KIND_LEAVES));
		send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'd4, KIND_LOG));
		send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'd5, KIND_BEDROCK));
		send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'd6, KIND_DIRT));
		send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'd7, KIND_UNK_LO));
		send_request(build_req(MODE_WRITE, 4'hF, 5'h1F, 4'hF, KIND_UNK_HI));
		send_request(build_req(MODE_IDLE, 4'hF, 5'h1F, 4'hF, KIND_UNK_HI));
		for (z = 1; z <= 7; z++)
			send_request(build_req(MODE_MESH, 4'hF, 5'h1F, 4'hF, KIND_UNK_HI));
		send_request(build_req(MODE_RESTART, '0, '0, '0, '0));
		send_request(build_req(MODE_MESH, '0, '0, '0, '0));
		send_request(build_req(MODE_MESH, '0, '0, '0, '0));
		wait_drained();
	endtask

	// write clusters near the scan start, then mesh through them
	task automatic test_random_episodes();
		vfcm_req_t r;
		int sent, i, count;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sink_mode = sink_mode_e'($urandom_range(0, 3));
			steady_feed = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				send_request(random_req(MODE_RESTART));
				sent++;
			end
			count = $urandom_range(2, 10);
			for (i = 0; i < count; i++) begin
				r = random_req(MODE_WRITE);
				if ($urandom_range(0, 9) != 0) begin
					r.pos_x_in = 4'($urandom_range(0, 1));
					r.pos_y_in = 5'($urandom_range(0, 2));
					if ($urandom_range(0, 4) != 0)
						r.block_kind = 3'($urandom_range(1, 7));
				end
				send_request(r);
				sent++;
				if ($urandom_range(0, 9) == 0)
					send_request(random_req(MODE_IDLE));
			end
			count = $urandom_range(4, 24);
			for (i = 0; i < count; i++) begin
				if ($urandom_range(0, 11) == 0)
					send_request(random_req(MODE_WRITE));
				else
					send_request(random_req(MODE_MESH));
				sent++;
			end
		end
		steady_feed = 1'b0;
		wait_drained();
	endtask

	// hold the output off while mesh requests keep coming
	task automatic test_output_stall();
		int z;
		sink_mode = SINK_OPEN;
		for (z = 0; z < CZ; z++)
			send_request(build_req(MODE_WRITE, 4'd0, 5'd0, 4'(z),
				(z % 2 == 0) ? random_solid() : KIND_AIR));
		send_request(random_req(MODE_RESTART));
		wait_drained();
		steady_feed = 1'b1;
		long_hold = 1'b1;
		for (z = 0; z < 20; z++)
			send_request(random_req(MODE_MESH));
		steady_feed = 1'b0;
		wait_drained();
	endtask

	// two solid rows with a leaves gap at the scan start, then mesh across both
	task automatic test_neighbor_mix();
		int y, z;
		steady_feed = 1'b1;
		sink_mode = SINK_PERIODIC;
		for (y = 0; y < 2; y++)
			for (z = 0; z < 8; z++)
				send_request(build_req(MODE_WRITE, 4'd0, 5'(y), 4'(z),
					(z == 3) ? KIND_LEAVES : random_solid()));
		send_request(random_req(MODE_RESTART));
		for (z = 0; z < 2 * CZ; z++)
			send_request(random_req(MODE_MESH));
		steady_feed = 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		scan_pos = 0;
		vertex_base = '0;
		foreach (voxel_kind[i])
			voxel_kind[i] = KIND_AIR;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_kinds_and_faces();
		test_random_episodes();
		test_output_stall();
		test_neighbor_mix();
		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
